>>> hdl/dtl_pkg.sv
// shared types and constants of the dfa token lexer
package dtl_pkg;

  // field widths
  localparam int unsigned CHAR_W  = 8;
  localparam int unsigned KIND_W  = 4;
  localparam int unsigned START_W = 16;
  localparam int unsigned LEN_W   = 8;

  // parameter defaults
  localparam int unsigned LEN_MAX_DEF  = 255;
  localparam int unsigned POS_BITS_DEF = 16;

  // result queue depth, a power of two
  localparam int unsigned RES_DEPTH = 4;

  // token kinds
  localparam logic [KIND_W-1:0] KIND_IDENT  = 4'd0;
  localparam logic [KIND_W-1:0] KIND_INT    = 4'd1;
  localparam logic [KIND_W-1:0] KIND_LIT    = 4'd2;
  localparam logic [KIND_W-1:0] KIND_GT     = 4'd3;
  localparam logic [KIND_W-1:0] KIND_GE     = 4'd4;
  localparam logic [KIND_W-1:0] KIND_ASSIGN = 4'd5;
  localparam logic [KIND_W-1:0] KIND_EQ     = 4'd6;
  localparam logic [KIND_W-1:0] KIND_PLUS   = 4'd7;
  localparam logic [KIND_W-1:0] KIND_MINUS  = 4'd8;
  localparam logic [KIND_W-1:0] KIND_STAR   = 4'd9;
  localparam logic [KIND_W-1:0] KIND_SLASH  = 4'd10;
  localparam logic [KIND_W-1:0] KIND_SEMI   = 4'd11;
  localparam logic [KIND_W-1:0] KIND_LPAREN = 4'd12;
  localparam logic [KIND_W-1:0] KIND_RPAREN = 4'd13;

  // one result item
  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [START_W-1:0] start;
    logic [LEN_W-1:0]   length;
    logic               last;
  } tok_t;

  // results of one processed item, first then second
  typedef struct packed {
    logic [1:0] num;
    tok_t       first;
    tok_t       second;
  } push_t;

endpackage

>>> hdl/dtl_if.sv
// channel interfaces for source bytes and tokens

interface dtl_in_if;
  logic                         valid;
  logic                         ready;
  logic [dtl_pkg::CHAR_W-1:0]   char_byte;
  logic                         end_of_input;

  modport source (output valid, output char_byte, output end_of_input, input ready);
  modport sink   (input valid, input char_byte, input end_of_input, output ready);
endinterface

interface dtl_out_if;
  logic                         valid;
  logic                         ready;
  logic [dtl_pkg::KIND_W-1:0]   token_kind;
  logic [dtl_pkg::START_W-1:0]  token_start;
  logic [dtl_pkg::LEN_W-1:0]    token_length;
  logic                         last_of_run;

  modport source (output valid, output token_kind, output token_start,
                  output token_length, output last_of_run, input ready);
  modport sink   (input valid, input token_kind, input token_start,
                  input token_length, input last_of_run, output ready);
endinterface

>>> hdl/dfa_token_lexer_core.sv
// top level of the dfa token lexer
// an accepted byte waits in the input register and is lexed once the token queue
//   has room; its tokens are written into the token queue, which registers them before they reach the output
// throughput: one byte per cycle while the four-entry token queue has room for
//   two tokens; the tokens of a byte that closes two leave the output one at a time
// reset: asynchronous, clears the lexer state, byte position and token queue
module dfa_token_lexer_core #(
  parameter int unsigned LEN_MAX  = dtl_pkg::LEN_MAX_DEF,
  parameter int unsigned POS_BITS = dtl_pkg::POS_BITS_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  dtl_in_if.sink    in_i,
  dtl_out_if.source out_o
);
  import dtl_pkg::*;

  logic              in_v_q;
  logic [CHAR_W-1:0] char_q;
  logic              last_q;
  logic              room, fire;
  push_t             push;
  tok_t              head;

  // input register
  assign fire       = in_v_q & room;
  assign in_i.ready = ~in_v_q | fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q <= 1'b0;
    end else if (in_i.ready) begin
      in_v_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      char_q <= in_i.char_byte;
      last_q <= in_i.end_of_input;
    end
  end

  // lexer
  dtl_lex_fsm #(
    .LEN_MAX  (LEN_MAX),
    .POS_BITS (POS_BITS)
  ) u_fsm (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (fire),
    .char_i (char_q),
    .last_i (last_q),
    .push_o (push)
  );

  // token queue
  dtl_res_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .room_o  (room),
    .valid_o (out_o.valid),
    .ready_i (out_o.ready),
    .head_o  (head)
  );

  assign out_o.token_kind   = head.kind;
  assign out_o.token_start  = head.start;
  assign out_o.token_length = head.length;
  assign out_o.last_of_run  = head.last;

endmodule

>>> hdl/dtl_lex_fsm.sv
// lexer state machine: token state, open token and byte position
module dtl_lex_fsm #(
  parameter int unsigned LEN_MAX  = dtl_pkg::LEN_MAX_DEF,
  parameter int unsigned POS_BITS = dtl_pkg::POS_BITS_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       fire_i,
  input  logic [dtl_pkg::CHAR_W-1:0] char_i,
  input  logic                       last_i,
  output dtl_pkg::push_t             push_o
);
  import dtl_pkg::*;

  localparam int unsigned LW = $clog2(LEN_MAX + 1);

  // lexer states
  localparam logic [3:0] ST_INIT = 4'd0;
  localparam logic [3:0] ST_ID   = 4'd1;
  localparam logic [3:0] ST_I1   = 4'd2;
  localparam logic [3:0] ST_I2   = 4'd3;
  localparam logic [3:0] ST_I3   = 4'd4;
  localparam logic [3:0] ST_GT   = 4'd5;
  localparam logic [3:0] ST_GE   = 4'd6;
  localparam logic [3:0] ST_AS   = 4'd7;
  localparam logic [3:0] ST_EQ   = 4'd8;
  localparam logic [3:0] ST_LIT  = 4'd9;
  localparam logic [3:0] ST_ONE  = 4'd10;

  // characters
  localparam logic [CHAR_W-1:0] CH_I     = 8'h69;
  localparam logic [CHAR_W-1:0] CH_N     = 8'h6e;
  localparam logic [CHAR_W-1:0] CH_T     = 8'h74;
  localparam logic [CHAR_W-1:0] CH_EQ    = 8'h3d;
  localparam logic [CHAR_W-1:0] CH_GT    = 8'h3e;
  localparam logic [CHAR_W-1:0] CH_SEMI  = 8'h3b;
  localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2b;
  localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2d;
  localparam logic [CHAR_W-1:0] CH_STAR  = 8'h2a;
  localparam logic [CHAR_W-1:0] CH_SLASH = 8'h2f;
  localparam logic [CHAR_W-1:0] CH_LP    = 8'h28;
  localparam logic [CHAR_W-1:0] CH_RP    = 8'h29;
  localparam logic [CHAR_W-1:0] CH_UNDER = 8'h5f;

  logic [3:0]          st_q, st_d;
  logic [KIND_W-1:0]   kind_q, kind_d;
  logic [POS_BITS-1:0] start_q, start_d;
  logic [LW-1:0]       len_q, len_d;
  logic [POS_BITS-1:0] pos_q, pos_d;

  logic                is_letter, is_digit, alnum, cont;
  logic [3:0]          st_mid, st_new, st_b;
  logic [KIND_W-1:0]   kind_mid, kind_new, kind_b;
  logic [POS_BITS-1:0] start_b;
  logic [LW-1:0]       len_b;
  logic                emit0, emit1;
  tok_t                r0, r1;

  // wide views for the fixed output fields
  logic [POS_BITS+START_W-1:0] start0_w, start1_w;
  logic [LW+LEN_W-1:0]         len0_w, len1_w;

  // character classes
  assign is_letter = (char_i inside {[8'h61:8'h7a], [8'h41:8'h5a], CH_UNDER});
  assign is_digit  = (char_i inside {[8'h30:8'h39]});
  assign alnum     = is_letter | is_digit;

  // continue the open token or not
  always_comb begin
    cont     = 1'b0;
    st_mid   = st_q;
    kind_mid = kind_q;
    case (st_q)
      ST_ID: begin
        cont = alnum;
      end
      ST_I1: begin
        if (char_i == CH_N) begin
          st_mid = ST_I2;
          cont   = 1'b1;
        end else if (alnum) begin
          st_mid = ST_ID;
          cont   = 1'b1;
        end
      end
      ST_I2: begin
        if (char_i == CH_T) begin
          st_mid   = ST_I3;
          kind_mid = KIND_INT;
          cont     = 1'b1;
        end else if (alnum) begin
          st_mid = ST_ID;
          cont   = 1'b1;
        end
      end
      ST_I3: begin
        if (alnum) begin
          st_mid   = ST_ID;
          kind_mid = KIND_IDENT;
          cont     = 1'b1;
        end
      end
      ST_GT: begin
        if (char_i == CH_EQ) begin
          st_mid   = ST_GE;
          kind_mid = KIND_GE;
          cont     = 1'b1;
        end
      end
      ST_AS: begin
        if (char_i == CH_EQ) begin
          st_mid   = ST_EQ;
          kind_mid = KIND_EQ;
          cont     = 1'b1;
        end
      end
      ST_LIT: begin
        cont = is_digit;
      end
      default: begin
      end
    endcase
  end

  // token opened by the current byte
  always_comb begin
    st_new   = ST_ONE;
    kind_new = KIND_IDENT;
    if (char_i == CH_I) begin
      st_new = ST_I1;
    end else if (is_letter) begin
      st_new = ST_ID;
    end else if (is_digit) begin
      st_new   = ST_LIT;
      kind_new = KIND_LIT;
    end else if (char_i == CH_GT) begin
      st_new   = ST_GT;
      kind_new = KIND_GT;
    end else if (char_i == CH_EQ) begin
      st_new   = ST_AS;
      kind_new = KIND_ASSIGN;
    end else if (char_i == CH_SEMI) begin
      kind_new = KIND_SEMI;
    end else if (char_i == CH_PLUS) begin
      kind_new = KIND_PLUS;
    end else if (char_i == CH_MINUS) begin
      kind_new = KIND_MINUS;
    end else if (char_i == CH_STAR) begin
      kind_new = KIND_STAR;
    end else if (char_i == CH_SLASH) begin
      kind_new = KIND_SLASH;
    end else if (char_i == CH_LP) begin
      kind_new = KIND_LPAREN;
    end else if (char_i == CH_RP) begin
      kind_new = KIND_RPAREN;
    end else begin
      st_new = ST_INIT;
    end
  end

  // state after the byte, before the end-of-input flush
  always_comb begin
    emit0 = 1'b0;
    if (cont) begin
      st_b    = st_mid;
      kind_b  = kind_mid;
      start_b = start_q;
      len_b   = (len_q < LW'(LEN_MAX)) ? len_q + LW'(1) : len_q;
    end else begin
      emit0 = (st_q != ST_INIT);
      st_b  = st_new;
      if (st_new == ST_INIT) begin
        kind_b  = KIND_IDENT;
        start_b = '0;
        len_b   = '0;
      end else begin
        kind_b  = kind_new;
        start_b = pos_q;
        len_b   = LW'(1);
      end
    end
    emit1 = last_i && (st_b != ST_INIT);
  end

  // result fields, sized to the output widths
  assign start0_w = {{START_W{1'b0}}, start_q};
  assign start1_w = {{START_W{1'b0}}, start_b};
  assign len0_w   = {{LEN_W{1'b0}}, len_q};
  assign len1_w   = {{LEN_W{1'b0}}, len_b};

  always_comb begin
    r0.kind   = kind_q;
    r0.start  = start0_w[START_W-1:0];
    r0.length = len0_w[LEN_W-1:0];
    r0.last   = ~emit1;
    r1.kind   = kind_b;
    r1.start  = start1_w[START_W-1:0];
    r1.length = len1_w[LEN_W-1:0];
    r1.last   = 1'b1;
  end

  // pack results in order
  always_comb begin
    push_o.first  = emit0 ? r0 : r1;
    push_o.second = r1;
    push_o.num    = 2'd0;
    if (fire_i) begin
      push_o.num = {1'b0, emit0} + {1'b0, emit1};
    end
  end

  // next state, reset after the last byte
  always_comb begin
    if (last_i) begin
      st_d    = ST_INIT;
      kind_d  = KIND_IDENT;
      start_d = '0;
      len_d   = '0;
      pos_d   = '0;
    end else begin
      st_d    = st_b;
      kind_d  = kind_b;
      start_d = start_b;
      len_d   = len_b;
      pos_d   = pos_q + POS_BITS'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q    <= ST_INIT;
      kind_q  <= KIND_IDENT;
      start_q <= '0;
      len_q   <= '0;
      pos_q   <= '0;
    end else if (fire_i) begin
      st_q    <= st_d;
      kind_q  <= kind_d;
      start_q <= start_d;
      len_q   <= len_d;
      pos_q   <= pos_d;
    end
  end

endmodule

>>> hdl/dtl_res_fifo.sv
// result queue: takes up to two tokens a cycle, hands out one
module dtl_res_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  dtl_pkg::push_t push_i,
  output logic           room_o,
  output logic           valid_o,
  input  logic           ready_i,
  output dtl_pkg::tok_t  head_o
);
  import dtl_pkg::*;

  localparam int unsigned PTR_W = $clog2(RES_DEPTH);
  localparam int unsigned CNT_W = PTR_W + 1;

  tok_t             mem_q [RES_DEPTH];
  logic [PTR_W-1:0] wp_q, wp_d, rp_q, rp_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             pop;

  assign valid_o = (cnt_q != '0);
  assign pop     = valid_o & ready_i;
  assign head_o  = mem_q[rp_q];

  // room for two tokens
  assign room_o = (cnt_q <= CNT_W'(RES_DEPTH - 2));

  // pointer and fill count
  always_comb begin
    wp_d  = wp_q + PTR_W'(push_i.num);
    rp_d  = rp_q + PTR_W'(pop);
    cnt_d = cnt_q + CNT_W'(push_i.num) - CNT_W'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      wp_q  <= wp_d;
      rp_q  <= rp_d;
      cnt_q <= cnt_d;
    end
  end

  // token storage
  always_ff @(posedge clk_i) begin
    if (push_i.num != 2'd0) begin
      mem_q[wp_q] <= push_i.first;
    end
    if (push_i.num == 2'd2) begin
      mem_q[wp_q + PTR_W'(1)] <= push_i.second;
    end
  end

endmodule

>>> hdl/dtl_checker.sv
// port-level checks of the dfa token lexer and their binding
module dtl_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        out_valid_i,
  input logic                        out_ready_i,
  input logic [dtl_pkg::KIND_W-1:0]  token_kind_i,
  input logic [dtl_pkg::START_W-1:0] token_start_i,
  input logic [dtl_pkg::LEN_W-1:0]   token_length_i,
  input logic                        last_of_run_i
);
  import dtl_pkg::*;

  // a stalled token holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(token_kind_i)
      && $stable(token_start_i) && $stable(token_length_i) && $stable(last_of_run_i))
    else $error("token changed while stalled");

  // only defined kinds
  a_kind_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> token_kind_i <= KIND_RPAREN)
    else $error("undefined token kind");

  // two-character operators
  a_len_two: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (token_kind_i == KIND_GE || token_kind_i == KIND_EQ)
      |-> token_length_i == 8'd2)
    else $error("two-character operator with wrong length");

  // single-character tokens
  a_len_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (token_kind_i == KIND_GT || token_kind_i == KIND_ASSIGN
      || token_kind_i == KIND_PLUS || token_kind_i == KIND_MINUS
      || token_kind_i == KIND_STAR || token_kind_i == KIND_SLASH
      || token_kind_i == KIND_SEMI || token_kind_i == KIND_LPAREN
      || token_kind_i == KIND_RPAREN) |-> token_length_i == 8'd1)
    else $error("single-character token with wrong length");

endmodule

bind dfa_token_lexer_core dtl_checker u_dtl_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_i    (out_o.valid),
  .out_ready_i    (out_o.ready),
  .token_kind_i   (out_o.token_kind),
  .token_start_i  (out_o.token_start),
  .token_length_i (out_o.token_length),
  .last_of_run_i  (out_o.last_of_run)
);
